/* sv/ufilt_pkg.sv */
// shared types and constants for the udp payload range filter
package ufilt_pkg;

    localparam int OFFSET_BITS = 16;

    localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = {OFFSET_BITS{1'b1}};

    localparam logic [OFFSET_BITS-1:0] PROTO_POS    = OFFSET_BITS'(9);
    localparam logic [OFFSET_BITS-1:0] DST_IP_FIRST = OFFSET_BITS'(16);
    localparam logic [OFFSET_BITS-1:0] DST_IP_LAST  = OFFSET_BITS'(19);
    localparam logic [OFFSET_BITS-1:0] PORT_HI_POS  = OFFSET_BITS'(2);
    localparam logic [OFFSET_BITS-1:0] PORT_LO_POS  = OFFSET_BITS'(3);
    localparam logic [OFFSET_BITS-1:0] PAYLOAD_POS  = OFFSET_BITS'(8);

    localparam logic [7:0] UDP_PROTO = 8'd17;

    localparam int ADDR_BITS = 4;

    typedef enum logic [1:0] {
        REG_MATCH_IP   = 2'd0,
        REG_MATCH_PORT = 2'd1,
        REG_MIN_BYTE   = 2'd2,
        REG_MAX_BYTE   = 2'd3
    } reg_idx_t;

    localparam logic [31:0] MATCH_IP_RST   = 32'h7F00_0001;
    localparam logic [15:0] MATCH_PORT_RST = 16'd8080;
    localparam logic [7:0]  MIN_BYTE_RST   = 8'h31;
    localparam logic [7:0]  MAX_BYTE_RST   = 8'h39;

    typedef struct packed {
        logic [31:0] match_ip;
        logic [15:0] match_port;
        logic [7:0]  min_byte;
        logic [7:0]  max_byte;
    } cfg_t;

    typedef struct packed {
        logic drop;
        logic rule_matched;
    } verdict_t;

endpackage

/* sv/udp_payload_range_filter_unit.sv */
// top level of the udp payload range filter: parser, registers, result buffer
//
// Packet bytes enter on the item channel (item_valid, item_stall, packet_byte,
// last_byte), starting at the first byte of the IPv4 header; last_byte marks
// the final byte. One verdict item (drop, rule_matched) leaves on the result
// channel (result_valid, result_stall) per packet, registered once the final
// byte is accepted. Bytes that are not final produce no result.
// Throughput is one byte per cycle while item_stall is low: header capture, the
// range check and the rule compare all happen in the cycle a byte is accepted,
// and the verdict is registered in a result register backed by one skid entry.
// item_stall rises only when both the result register and the skid entry
// hold verdicts, i.e. after result_stall has held two packets back; it drops
// the cycle after the receiver takes one.
// Rule registers sit on the APB port: match_ip at 0x0, match_port at 0x4,
// min_byte at 0x8, max_byte at 0xC; write them only while the block is idle.
// Reset clears the packet state and both result entries and loads the rule
// 127.0.0.1 port 8080 with the payload range '1'..'9'.
module udp_payload_range_filter_unit
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    output logic                            item_stall,
    input  logic [7:0]                      packet_byte,
    input  logic                            last_byte,
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic                            drop,
    output logic                            rule_matched,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ufilt_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    ufilt_pkg::cfg_t     cfg;
    ufilt_pkg::verdict_t new_res;
    logic                new_valid;
    logic                take;
    logic                out_take;

    logic                out_valid_reg;
    ufilt_pkg::verdict_t out_reg;
    logic                skid_valid_reg;
    ufilt_pkg::verdict_t skid_reg;

    assign item_stall = skid_valid_reg;
    assign take       = item_valid && !skid_valid_reg;
    assign out_take   = out_valid_reg && !result_stall;

    ufilt_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ufilt_parse u_parse
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .packet_byte (packet_byte),
        .last_byte   (last_byte),
        .cfg         (cfg),
        .res_valid   (new_valid),
        .res         (new_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_take)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= new_valid;
            end
        end
        else if (new_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_take)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (new_valid)
                out_reg <= new_res;
        end
        else if (new_valid)
        begin
            skid_reg <= new_res;
        end
    end

    assign result_valid = out_valid_reg;
    assign drop         = out_reg.drop;
    assign rule_matched = out_reg.rule_matched;

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry full while result register empty");

    a_drop_needs_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!out_reg.drop || out_reg.rule_matched))
        else $error("drop verdict without a rule match");

    a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !out_take) |=> (skid_valid_reg && $stable(skid_reg)))
        else $error("skid entry lost while result stalled");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_take && new_valid) |=> skid_valid_reg)
        else $error("verdict dropped with result register full");

endmodule

/* sv/ufilt_regs.sv */
// apb configuration registers of the udp payload range filter
module ufilt_regs
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ufilt_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output ufilt_pkg::cfg_t                cfg
);

    ufilt_pkg::cfg_t  cfg_reg;
    logic             wr_en;
    ufilt_pkg::reg_idx_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = ufilt_pkg::reg_idx_t'(paddr[3:2]);
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.match_ip   <= ufilt_pkg::MATCH_IP_RST;
            cfg_reg.match_port <= ufilt_pkg::MATCH_PORT_RST;
            cfg_reg.min_byte   <= ufilt_pkg::MIN_BYTE_RST;
            cfg_reg.max_byte   <= ufilt_pkg::MAX_BYTE_RST;
        end
        else if (wr_en)
        begin
            case (idx)
                ufilt_pkg::REG_MATCH_IP:   cfg_reg.match_ip   <= pwdata;
                ufilt_pkg::REG_MATCH_PORT: cfg_reg.match_port <= pwdata[15:0];
                ufilt_pkg::REG_MIN_BYTE:   cfg_reg.min_byte   <= pwdata[7:0];
                ufilt_pkg::REG_MAX_BYTE:   cfg_reg.max_byte   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            ufilt_pkg::REG_MATCH_IP:   prdata = cfg_reg.match_ip;
            ufilt_pkg::REG_MATCH_PORT: prdata = {16'd0, cfg_reg.match_port};
            ufilt_pkg::REG_MIN_BYTE:   prdata = {24'd0, cfg_reg.min_byte};
            ufilt_pkg::REG_MAX_BYTE:   prdata = {24'd0, cfg_reg.max_byte};
            default:                   prdata = 32'd0;
        endcase
    end

endmodule

/* sv/ufilt_parse.sv */
// per-packet header capture, payload range check and verdict logic
module ufilt_parse
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 take,
    input  logic [7:0]           packet_byte,
    input  logic                 last_byte,
    input  ufilt_pkg::cfg_t      cfg,
    output logic                 res_valid,
    output ufilt_pkg::verdict_t  res
);

    localparam int OB = ufilt_pkg::OFFSET_BITS;

    logic [OB-1:0] offset_reg;
    logic [OB-1:0] offset_next;
    logic [3:0]    hdr_words_reg;
    logic [3:0]    hdr_words_next;
    logic [7:0]    proto_reg;
    logic [7:0]    proto_next;
    logic [31:0]   ip_reg;
    logic [31:0]   ip_next;
    logic [15:0]   port_reg;
    logic [15:0]   port_next;
    logic          bad_reg;
    logic          bad_next;

    logic [OB-1:0] hdr_len;
    logic          ready;
    logic          matched;

    always_comb
    begin
        hdr_words_next = (offset_reg == '0) ? packet_byte[3:0] : hdr_words_reg;
        hdr_len        = OB'({hdr_words_next, 2'b00});

        proto_next = (offset_reg == ufilt_pkg::PROTO_POS) ? packet_byte : proto_reg;

        ip_next = ip_reg;
        if (offset_reg >= ufilt_pkg::DST_IP_FIRST && offset_reg <= ufilt_pkg::DST_IP_LAST)
        begin
            case (offset_reg[1:0])
                2'd0:    ip_next[31:24] = packet_byte;
                2'd1:    ip_next[23:16] = packet_byte;
                2'd2:    ip_next[15:8]  = packet_byte;
                default: ip_next[7:0]   = packet_byte;
            endcase
        end

        port_next = port_reg;
        if (offset_reg == hdr_len + ufilt_pkg::PORT_HI_POS)
            port_next[15:8] = packet_byte;
        if (offset_reg == hdr_len + ufilt_pkg::PORT_LO_POS)
            port_next[7:0] = packet_byte;

        bad_next = bad_reg;
        if (offset_reg >= hdr_len + ufilt_pkg::PAYLOAD_POS &&
            (packet_byte < cfg.min_byte || packet_byte > cfg.max_byte))
            bad_next = 1'b1;

        ready   = offset_reg >= ufilt_pkg::DST_IP_LAST &&
                  offset_reg >= hdr_len + ufilt_pkg::PORT_LO_POS;
        matched = ready && proto_next == ufilt_pkg::UDP_PROTO &&
                  ip_next == cfg.match_ip && port_next == cfg.match_port;

        offset_next = (offset_reg == ufilt_pkg::OFFSET_MAX) ? offset_reg
                                                             : offset_reg + OB'(1);
    end

    assign res_valid        = take && last_byte;
    assign res.drop         = matched && bad_next;
    assign res.rule_matched = matched;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg    <= '0;
            hdr_words_reg <= '0;
            proto_reg     <= '0;
            ip_reg        <= '0;
            port_reg      <= '0;
            bad_reg       <= 1'b0;
        end
        else if (take)
        begin
            if (last_byte)
            begin
                offset_reg    <= '0;
                hdr_words_reg <= '0;
                proto_reg     <= '0;
                ip_reg        <= '0;
                port_reg      <= '0;
                bad_reg       <= 1'b0;
            end
            else
            begin
                offset_reg    <= offset_next;
                hdr_words_reg <= hdr_words_next;
                proto_reg     <= proto_next;
                ip_reg        <= ip_next;
                port_reg      <= port_next;
                bad_reg       <= bad_next;
            end
        end
    end

endmodule

/* dv/udp_payload_range_filter_unit_tb.sv */
// testbench for the udp payload range filter: packet stimulus, verdict prediction and checking
module udp_payload_range_filter_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1_000_000;

    localparam logic [31:0] HOME_IP   = ufilt_pkg::MATCH_IP_RST;
    localparam logic [15:0] HOME_PORT = ufilt_pkg::MATCH_PORT_RST;
    localparam logic [7:0]  UDP       = ufilt_pkg::UDP_PROTO;

    localparam ufilt_pkg::cfg_t RULE_RST   = '{ufilt_pkg::MATCH_IP_RST,
                                               ufilt_pkg::MATCH_PORT_RST,
                                               ufilt_pkg::MIN_BYTE_RST,
                                               ufilt_pkg::MAX_BYTE_RST};
    localparam ufilt_pkg::cfg_t RULE_ONES  = '{32'hFFFF_FFFF, 16'hFFFF, 8'h00, 8'hFF};
    localparam ufilt_pkg::cfg_t RULE_EMPTY = '{32'h0000_0000, 16'h0000, 8'hFF, 8'h00};
    localparam ufilt_pkg::cfg_t RULE_POINT = '{32'h0000_0000, 16'h0000, 8'h80, 8'h80};

    localparam ufilt_pkg::verdict_t V_PASS = '{drop: 1'b0, rule_matched: 1'b0};
    localparam ufilt_pkg::verdict_t V_HIT  = '{drop: 1'b0, rule_matched: 1'b1};
    localparam ufilt_pkg::verdict_t V_DROP = '{drop: 1'b1, rule_matched: 1'b1};

    typedef struct {
        bit                  new_rule;
        ufilt_pkg::cfg_t     rule_val;
        logic [3:0]          ihl;
        logic [7:0]          proto;
        logic [31:0]         ip;
        logic [15:0]         port;
        int                  len;
        logic [7:0]          fill;
        logic [7:0]          tail;
        bit                  known;
        ufilt_pkg::verdict_t want;
    } plan_row_t;

    typedef struct {
        bit                  known;
        ufilt_pkg::verdict_t want;
    } pkt_note_t;

    // payload is fill bytes with the tail byte last
    plan_row_t plan [21] = '{
        '{1'b0, RULE_RST, 4'd5, UDP, HOME_IP, HOME_PORT, 32, 8'h35, 8'h35, 1'b1, V_HIT},
        '{1'b0, RULE_RST, 4'd5, UDP, HOME_IP, HOME_PORT, 32, 8'h35, 8'h30, 1'b1, V_DROP},
        '{1'b0, RULE_RST, 4'd5, UDP, HOME_IP, HOME_PORT, 32, 8'h35, 8'h3A, 1'b1, V_DROP},
        '{1'b0, RULE_RST, 4'd5, UDP, HOME_IP, HOME_PORT, 32, 8'h31, 8'h39, 1'b1, V_HIT},
        '{1'b0, RULE_RST, 4'd5, UDP, HOME_IP, HOME_PORT, 29, 8'h00, 8'h00, 1'b1, V_DROP},
        '{1'b0, RULE_RST, 4'd5, UDP, HOME_IP, HOME_PORT, 29, 8'hFF, 8'hFF, 1'b1, V_DROP},
        '{1'b0, RULE_RST, 4'd5, 8'd6, HOME_IP, HOME_PORT, 32, 8'h00, 8'h00, 1'b1, V_PASS},
        '{1'b0, RULE_RST, 4'd5, UDP, 32'h7F00_0002, HOME_PORT, 32, 8'h00, 8'h00,
          1'b1, V_PASS},
        '{1'b0, RULE_RST, 4'd5, UDP, HOME_IP, 16'd8081, 32, 8'h00, 8'h00, 1'b1, V_PASS},
        // no payload, then packets cut short
        '{1'b0, RULE_RST, 4'd5, UDP, HOME_IP, HOME_PORT, 28, 8'h00, 8'h00, 1'b1, V_HIT},
        '{1'b0, RULE_RST, 4'd5, UDP, HOME_IP, HOME_PORT, 24, 8'h00, 8'h00, 1'b1, V_HIT},
        '{1'b0, RULE_RST, 4'd5, UDP, HOME_IP, HOME_PORT, 23, 8'h00, 8'h00, 1'b1, V_PASS},
        '{1'b0, RULE_RST, 4'd5, UDP, HOME_IP, HOME_PORT, 20, 8'h00, 8'h00, 1'b1, V_PASS},
        '{1'b0, RULE_RST, 4'd5, UDP, HOME_IP, HOME_PORT, 1, 8'h00, 8'h00, 1'b1, V_PASS},
        // odd header lengths
        '{1'b0, RULE_RST, 4'd0, UDP, HOME_IP, HOME_PORT, 24, 8'h35, 8'h00, 1'b0, V_PASS},
        '{1'b0, RULE_RST, 4'd4, UDP, HOME_IP, HOME_PORT, 30, 8'h33, 8'h33, 1'b0, V_PASS},
        '{1'b0, RULE_RST, 4'd15, UDP, HOME_IP, HOME_PORT, 72, 8'h35, 8'h40, 1'b0, V_PASS},
        '{1'b1, RULE_ONES, 4'd5, UDP, 32'hFFFF_FFFF, 16'hFFFF, 30, 8'hFF, 8'h00,
          1'b1, V_HIT},
        '{1'b1, RULE_EMPTY, 4'd5, UDP, 32'h0, 16'h0, 29, 8'h80, 8'h80, 1'b1, V_DROP},
        '{1'b1, RULE_POINT, 4'd5, UDP, 32'h0, 16'h0, 30, 8'h80, 8'h80, 1'b1, V_HIT},
        '{1'b0, RULE_POINT, 4'd5, UDP, 32'h0, 16'h0, 30, 8'h80, 8'h7F, 1'b1, V_DROP}
    };

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            item_valid = 1'b0;
    logic                            item_stall;
    logic [7:0]                      packet_byte = 8'h00;
    logic                            last_byte = 1'b0;
    logic                            result_valid;
    logic                            result_stall = 1'b0;
    logic                            drop;
    logic                            rule_matched;
    logic                            psel = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite = 1'b0;
    logic [ufilt_pkg::ADDR_BITS-1:0] paddr = '0;
    logic [31:0]                     pwdata = '0;
    logic [31:0]                     prdata;
    logic                            pready;
    logic                            byte_taken;

    ufilt_pkg::cfg_t                   rule = RULE_RST;
    logic [ufilt_pkg::OFFSET_BITS-1:0] byte_ofs = '0;
    logic [3:0]                        hdr_words = '0;
    logic [7:0]                        cur_proto = '0;
    logic [31:0]                       cur_ip = '0;
    logic [15:0]                       cur_port = '0;
    logic                              bad_seen = 1'b0;

    ufilt_pkg::verdict_t expected_verdicts[$];
    pkt_note_t           typed_verdicts[$];
    int                  packets_sent = 0;
    int                  verdicts_seen = 0;
    int                  mismatches = 0;
    int                  cycles = 0;
    int                  send_pct = 0;
    int                  stall_pct = 0;

    udp_payload_range_filter_unit uut (.*);

    assign byte_taken = item_valid && !item_stall;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        result_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic predict_verdict(input logic [7:0] b, input logic fin);
        int unsigned         ofs;
        int unsigned         hdr;
        logic                matched;
        ufilt_pkg::verdict_t v;
        pkt_note_t           note;
        ofs = byte_ofs;
        if (ofs == 0)
            hdr_words = b[3:0];
        hdr = hdr_words * 4;
        if (ofs == ufilt_pkg::PROTO_POS)
            cur_proto = b;
        if (ofs >= ufilt_pkg::DST_IP_FIRST && ofs <= ufilt_pkg::DST_IP_LAST)
            cur_ip[(ufilt_pkg::DST_IP_LAST - ofs) * 8 +: 8] = b;
        if (ofs == hdr + ufilt_pkg::PORT_HI_POS)
            cur_port[15:8] = b;
        if (ofs == hdr + ufilt_pkg::PORT_LO_POS)
            cur_port[7:0] = b;
        if (ofs >= hdr + ufilt_pkg::PAYLOAD_POS &&
            (b < rule.min_byte || b > rule.max_byte))
            bad_seen = 1'b1;
        if (fin)
        begin
            matched = ofs >= ufilt_pkg::DST_IP_LAST && ofs >= hdr + ufilt_pkg::PORT_LO_POS &&
                      cur_proto == ufilt_pkg::UDP_PROTO && cur_ip == rule.match_ip &&
                      cur_port == rule.match_port;
            v.drop = matched && bad_seen;
            v.rule_matched = matched;
            if (typed_verdicts.size() != 0)
            begin
                note = typed_verdicts.pop_front();
                if (note.known)
                    v = note.want;
            end
            expected_verdicts.push_back(v);
            byte_ofs = '0;
            hdr_words = '0;
            cur_proto = '0;
            cur_ip = '0;
            cur_port = '0;
            bad_seen = 1'b0;
        end
        else if (byte_ofs != ufilt_pkg::OFFSET_MAX)
        begin
            byte_ofs = byte_ofs + 1'b1;
        end
    endtask

    always @(posedge clk)
    begin : verdict_check
        ufilt_pkg::verdict_t w;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    $error("verdict item with none expected: drop %0b rule_matched %0b",
                           drop, rule_matched);
                    mismatches++;
                end
                else
                begin
                    w = expected_verdicts.pop_front();
                    if (drop !== w.drop)
                    begin
                        $error("drop: expected %0b, got %0b", w.drop, drop);
                        mismatches++;
                    end
                    if (rule_matched !== w.rule_matched)
                    begin
                        $error("rule_matched: expected %0b, got %0b",
                               w.rule_matched, rule_matched);
                        mismatches++;
                    end
                    verdicts_seen++;
                end
            end
            if (byte_taken)
                predict_verdict(packet_byte, last_byte);
        end
    end

    task automatic write_rules(input ufilt_pkg::cfg_t c);
        ufilt_pkg::reg_idx_t idx;
        for (int i = 0; i < 4; i++)
        begin
            idx = ufilt_pkg::reg_idx_t'(i);
            psel <= 1'b1;
            penable <= 1'b0;
            pwrite <= 1'b1;
            paddr <= {idx, 2'b00};
            case (idx)
                ufilt_pkg::REG_MATCH_IP:   pwdata <= c.match_ip;
                ufilt_pkg::REG_MATCH_PORT: pwdata <= 32'(c.match_port);
                ufilt_pkg::REG_MIN_BYTE:   pwdata <= 32'(c.min_byte);
                ufilt_pkg::REG_MAX_BYTE:   pwdata <= 32'(c.max_byte);
                default:                   pwdata <= '0;
            endcase
            @(posedge clk);
            penable <= 1'b1;
            do
                @(posedge clk);
            while (!pready);
        end
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        rule = c;
    endtask

    task automatic settle();
        item_valid <= 1'b0;
        while (verdicts_seen != packets_sent)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // negative bad_pct selects fill/tail payload, else random with that share left unconstrained
    task automatic send_packet(input logic [3:0] ihl, input logic [7:0] proto,
                               input logic [31:0] ip, input logic [15:0] port,
                               input int len, input logic [7:0] fill,
                               input logic [7:0] tail, input int bad_pct,
                               input bit known, input ufilt_pkg::verdict_t want);
        int         hdr;
        logic [7:0] b;
        typed_verdicts.push_back('{known, want});
        packets_sent++;
        hdr = int'(ihl) * 4;
        for (int i = 0; i < len; i++)
        begin
            b = 8'($urandom);
            if (i == 0)
                b = {b[7:4], ihl};
            else if (i == hdr + 2)
                b = port[15:8];
            else if (i == hdr + 3)
                b = port[7:0];
            else if (i == 9)
                b = proto;
            else if (i >= 16 && i <= 19)
                b = ip[(19 - i) * 8 +: 8];
            else if (i >= hdr + 8)
            begin
                if (bad_pct < 0)
                    b = (i == len - 1) ? tail : fill;
                else if (rule.min_byte <= rule.max_byte && $urandom_range(99) >= bad_pct)
                    b = 8'($urandom_range(rule.max_byte, rule.min_byte));
            end
            while ($urandom_range(99) < send_pct)
            begin
                item_valid <= 1'b0;
                @(posedge clk);
            end
            item_valid <= 1'b1;
            packet_byte <= b;
            last_byte <= (i == len - 1);
            do
                @(posedge clk);
            while (!byte_taken);
        end
    endtask

    initial
    begin
        ufilt_pkg::cfg_t c;
        logic [3:0]      ihl;
        logic [7:0]      proto;
        logic [31:0]     ip;
        logic [15:0]     port;
        logic [7:0]      lo;
        logic [7:0]      hi;
        int              hdr;
        int              len;
        int              sent;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].new_rule)
            begin
                settle();
                write_rules(plan[i].rule_val);
            end
            send_packet(plan[i].ihl, plan[i].proto, plan[i].ip, plan[i].port, plan[i].len,
                        plan[i].fill, plan[i].tail, -1, plan[i].known, plan[i].want);
        end

        for (int ph = 0; ph < 4; ph++)
        begin
            settle();
            c.match_ip = $urandom;
            c.match_port = 16'($urandom);
            lo = 8'($urandom);
            hi = 8'($urandom);
            case (ph)
                0:
                begin
                    c = '{32'h0, 16'h0, 8'h00, 8'hFF};
                    send_pct = 0;
                    stall_pct <= 0;
                end
                1:
                begin
                    c = '{32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 8'h00};
                    send_pct = 73;
                    stall_pct <= 0;
                end
                2:
                begin
                    c.min_byte = lo;
                    c.max_byte = lo;
                    send_pct = 0;
                    stall_pct <= 73;
                end
                default:
                begin
                    c.min_byte = (lo < hi) ? lo : hi;
                    c.max_byte = (lo < hi) ? hi : lo;
                    send_pct = 11;
                    stall_pct <= 11;
                end
            endcase
            write_rules(c);
            sent = 0;
            while (sent < 210)
            begin
                ihl = ($urandom_range(99) < 80) ? 4'd5 : 4'($urandom);
                proto = ($urandom_range(99) < 85) ? UDP : 8'($urandom);
                ip = ($urandom_range(99) < 85) ? rule.match_ip :
                     rule.match_ip ^ (32'd1 << $urandom_range(31));
                port = ($urandom_range(99) < 85) ? rule.match_port :
                       rule.match_port ^ (16'd1 << $urandom_range(15));
                hdr = int'(ihl) * 4;
                len = ((hdr + 8 > 20) ? hdr + 8 : 20) + $urandom_range(12);
                // truncated packets
                if ($urandom_range(99) < 12)
                    len = $urandom_range(hdr + 8, 1);
                send_packet(ihl, proto, ip, port, len, 8'h00, 8'h00,
                            ($urandom_range(99) < 60) ? 0 : 15, 1'b0, V_PASS);
                sent += len;
            end
        end

        settle();
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
